### sv/mpt_pkg.sv
package mpt_pkg;

    localparam int unsigned IDX_W  = 5;
    localparam int unsigned PFX_W  = 24;
    localparam int unsigned ETH_W  = 48;
    localparam int unsigned LP_W   = 64;
    localparam int unsigned STS_W  = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W  = 2;

    typedef logic [STS_W-1:0] t_status;

    localparam t_status STS_DIRECT  = 3'd0;
    localparam t_status STS_KNOWN   = 3'd1;
    localparam t_status STS_ADDED   = 3'd2;
    localparam t_status STS_UNKNOWN = 3'd3;
    localparam t_status STS_FULL    = 3'd4;

    typedef logic [CFG_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_MARKER_A = 2'd0;
    localparam t_cfg_index CFG_MARKER_B = 2'd1;

    localparam logic [BYTE_W-1:0] MARKER_A_RST = 8'd255;
    localparam logic [BYTE_W-1:0] MARKER_B_RST = 8'd254;

    // translate and local set, multicast clear
    localparam logic [2:0] TR_PATTERN = 3'b110;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_SEARCH
    } t_state;

endpackage

### sv/mac_prefix_translator_unit.sv
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_stall    | i_action, i_eth_addr, i_lowpan_addr
// output  | out       | o_out_valid / i_out_stall  | o_lowpan_out, o_eth_out, o_status
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item at a time. Direct copies need no table read; Ethernet addresses carrying an
// index take one table read. A lowpan prefix search ends at the first hit or after all
// prefix_count entries on a miss, one compare per cycle on the single read port.
// Reset clears the entry count and presets markers to 255/254; entries at or past the count
// read as zero. A stalled result holds the unit before it loads the output register.
module mac_prefix_translator_unit #(
    parameter int unsigned PREFIX_SLOTS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [mpt_pkg::ETH_W-1:0]   i_eth_addr,
    input  logic [mpt_pkg::LP_W-1:0]    i_lowpan_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mpt_pkg::LP_W-1:0]    o_lowpan_out,
    output logic [mpt_pkg::ETH_W-1:0]   o_eth_out,
    output logic [mpt_pkg::STS_W-1:0]   o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mpt_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [mpt_pkg::BYTE_W-1:0]  i_cfg_data
);
    import mpt_pkg::*;

    localparam int unsigned AW = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
    localparam int unsigned CW = $clog2(PREFIX_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(PREFIX_SLOTS);

    logic [PFX_W-1:0] mem [PREFIX_SLOTS];
    logic [PFX_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic              r_action;
    logic [ETH_W-1:0]  r_eth;
    logic [LP_W-1:0]   r_lp;
    logic [BYTE_W-1:0] r_ma, r_mb;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_out_vld, n_out_vld;
    logic [LP_W-1:0]   r_lowpan_out;
    logic [ETH_W-1:0]  r_eth_out;
    t_status           r_status;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [LP_W-1:0]   res_lp;
    logic [ETH_W-1:0]  res_eth;
    t_status           res_status;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] b0;
    logic [IDX_W-1:0]  eth_idx;
    logic              idx_known;
    logic [PFX_W-1:0]  pfx_lp;
    logic              marker_hit;
    logic              hit;
    logic [LP_W-1:0]   direct_lp;
    logic [ETH_W-1:0]  direct_eth;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign out_free     = !r_out_vld || !i_out_stall;
    assign o_out_valid  = r_out_vld;
    assign o_lowpan_out = r_lowpan_out;
    assign o_eth_out    = r_eth_out;
    assign o_status     = r_status;
    assign o_cfg_ready  = 1'b1;

    assign b0         = r_eth[ETH_W-1 -: BYTE_W];
    assign eth_idx    = b0[BYTE_W-1 -: IDX_W];
    assign idx_known  = {1'b0, eth_idx} < (IDX_W+1)'(r_count);
    assign pfx_lp     = r_lp[LP_W-1 -: PFX_W];
    assign marker_hit = (r_lp[39:32] == r_ma) && (r_lp[31:24] == r_mb);
    assign hit        = r_cmp_vld && (r_rd_data == pfx_lp);
    assign direct_lp  = {r_eth[47:24], r_ma, r_mb, r_eth[23:0]};
    assign direct_eth = {r_lp[63:40], r_lp[23:0]};

    always_comb begin
        if (r_state == ST_SEARCH) begin
            rd_addr = hit ? r_cmp_idx : r_idx[AW-1:0];
        end else begin
            rd_addr = AW'(eth_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= pfx_lp;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_out_vld  = r_out_vld && i_out_stall;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        res_lp     = '0;
        res_eth    = '0;
        res_status = STS_DIRECT;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!r_action) begin
                    if (b0[2:0] == TR_PATTERN) begin
                        n_state = ST_LOOKUP;
                    end else begin
                        res_lp   = direct_lp;
                        out_load = out_free;
                    end
                end else if (marker_hit) begin
                    res_eth  = direct_eth;
                    out_load = out_free;
                end else begin
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_SEARCH;
                end
            end
            ST_LOOKUP: begin
                res_lp     = {idx_known ? r_rd_data : {PFX_W{1'b0}}, r_eth[39:0]};
                res_status = idx_known ? STS_KNOWN : STS_UNKNOWN;
                out_load   = out_free;
            end
            ST_SEARCH: begin
                if (hit) begin
                    res_eth    = {IDX_W'(r_cmp_idx), TR_PATTERN, r_lp[39:0]};
                    res_status = STS_KNOWN;
                    out_load   = out_free;
                end else if (r_idx < r_count) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                    out_load  = out_free;
                    if (r_count < SLOTS_C) begin
                        res_eth    = {IDX_W'(r_count), TR_PATTERN, r_lp[39:0]};
                        res_status = STS_ADDED;
                        wr_en      = out_free;
                        if (out_free) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        res_eth    = direct_eth;
                        res_status = STS_FULL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
            n_state   = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_ma      <= MARKER_A_RST;
            r_mb      <= MARKER_B_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && i_cfg_index == CFG_MARKER_A) begin
                r_ma <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_MARKER_B) begin
                r_mb <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        if (accept) begin
            r_action <= i_action;
            r_eth    <= i_eth_addr;
            r_lp     <= i_lowpan_addr;
        end
        if (out_load) begin
            r_lowpan_out <= res_lp;
            r_eth_out    <= res_eth;
            r_status     <= res_status;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("prefix count past table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("prefix count did not advance on table write");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> r_count == $past(r_count))
        else $error("prefix count changed without table write");

    a_write_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> out_load && res_status == STS_ADDED)
        else $error("table write without added result");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_idx <= r_count)
        else $error("search index past entry count");
`endif

endmodule
